// ----- sv/brl_pkg.sv -----
// ----------------------------------------------------------------------------
// brl_pkg - shared types and constants for the line rasterizer
// Holds the walker state type and the guard width used for the error term.
// ----------------------------------------------------------------------------
`default_nettype none

package brl_pkg;

   // The error term needs this many bits beyond a coordinate. It covers the
   // sign, the dx - dz span and headroom for the add/sub step.
   localparam int unsigned ERR_GUARD_BITS = 3;

   typedef enum logic [1:0] {
      BRL_IDLE,
      BRL_LOAD,
      BRL_WALK
   } brl_state_type;

endpackage : brl_pkg

`default_nettype wire

// ----- sv/brl_front.sv -----
// ----------------------------------------------------------------------------
// brl_front - line command setup
// Derives deltas, step directions and the initial error from one command and
// packs them into a setup record for the walker queue.
// ----------------------------------------------------------------------------
`default_nettype none

module brl_front #(
   parameter int unsigned COORD_BITS = 6,
   parameter int unsigned REC_BITS   = 7 * COORD_BITS + brl_pkg::ERR_GUARD_BITS + 2
) (
   input  wire logic [COORD_BITS-1:0] start_x,
   input  wire logic [COORD_BITS-1:0] start_z,
   input  wire logic [COORD_BITS-1:0] end_x,
   input  wire logic [COORD_BITS-1:0] end_z,
   output      logic [REC_BITS-1:0]   setup_rec
);

   localparam int unsigned EW = COORD_BITS + brl_pkg::ERR_GUARD_BITS;

   logic [COORD_BITS-1:0] dx;
   logic [COORD_BITS-1:0] dz;
   logic                  sx_neg;
   logic                  sz_neg;
   logic [EW-1:0]         err_init;

   always_comb begin
      dx       = (end_x >= start_x) ? (end_x - start_x) : (start_x - end_x);
      dz       = (end_z >= start_z) ? (end_z - start_z) : (start_z - end_z);
      // step is -1 unless start is strictly below end
      sx_neg   = !(start_x < end_x);
      sz_neg   = !(start_z < end_z);
      err_init = EW'(dx) - EW'(dz);
   end

   // Record layout, low bits first: start_x, start_z, end_x, end_z, dx, dz,
   // sx_neg, sz_neg, err.
   assign setup_rec = {err_init, sz_neg, sx_neg, dz, dx, end_z, end_x, start_z, start_x};

endmodule : brl_front

`default_nettype wire

// ----- sv/brl_fifo.sv -----
// ----------------------------------------------------------------------------
// brl_fifo - setup record queue
// Small synchronous queue between command setup and the point walker.
// Read data is registered: it appears the cycle after a pop.
// ----------------------------------------------------------------------------
`default_nettype none

module brl_fifo #(
   parameter int unsigned WIDTH = 50,
   parameter int unsigned DEPTH = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   input  wire logic             pop,
   output      logic [WIDTH-1:0] pop_data,
   output      logic             full,
   output      logic             not_empty
);

   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff;
   logic [AW-1:0]    wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff;
   logic [AW-1:0]    rd_ptr_in;
   logic [CW-1:0]    count_ff;
   logic [CW-1:0]    count_in;
   logic [WIDTH-1:0] pop_data_ff;

   assign full      = (count_ff == CW'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_data  = pop_data_ff;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         pop_data_ff <= mem_ff[rd_ptr_ff];
      end
   end

endmodule : brl_fifo

`default_nettype wire

// ----- sv/brl_back.sv -----
// ----------------------------------------------------------------------------
// brl_back - Bresenham point walker
// Takes one setup record at a time and steps the line into a registered
// result beat, one point per cycle while that register is free or taken.
// ----------------------------------------------------------------------------
`default_nettype none

module brl_back #(
   parameter int unsigned COORD_BITS = 6,
   parameter int unsigned REC_BITS   = 7 * COORD_BITS + brl_pkg::ERR_GUARD_BITS + 2
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  rec_avail,
   input  wire logic [REC_BITS-1:0]   rec_data,
   output      logic                  rec_pop,
   output      logic                  pt_valid,
   input  wire logic                  pt_ready,
   output      logic [COORD_BITS-1:0] pt_x,
   output      logic [COORD_BITS-1:0] pt_z,
   output      logic                  pt_last
);

   localparam int unsigned CB = COORD_BITS;
   localparam int unsigned EW = CB + brl_pkg::ERR_GUARD_BITS;

   brl_pkg::brl_state_type state_ff;
   brl_pkg::brl_state_type state_in;

   logic [CB-1:0]        px_ff, px_in;
   logic [CB-1:0]        pz_ff, pz_in;
   logic [CB-1:0]        ex_ff;
   logic [CB-1:0]        ez_ff;
   logic [CB-1:0]        dx_ff;
   logic [CB-1:0]        dz_ff;
   logic                 sx_neg_ff;
   logic                 sz_neg_ff;
   logic signed [EW-1:0] err_ff, err_in;

   logic                 out_valid_ff, out_valid_in;
   logic [CB-1:0]        out_x_ff;
   logic [CB-1:0]        out_z_ff;
   logic                 out_last_ff;

   logic                 out_free;
   logic                 emit;
   logic                 done;
   logic                 x_step;
   logic                 z_step;
   logic signed [EW:0]   e2;
   logic signed [EW:0]   dx_w;
   logic signed [EW:0]   dz_w;

   assign out_free = !out_valid_ff || pt_ready;
   assign done     = (px_ff == ex_ff) && (pz_ff == ez_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         brl_pkg::BRL_IDLE: begin
            if (rec_avail) begin
               state_in = brl_pkg::BRL_LOAD;
            end
         end
         brl_pkg::BRL_LOAD: begin
            state_in = brl_pkg::BRL_WALK;
         end
         brl_pkg::BRL_WALK: begin
            if (out_free && done) begin
               state_in = brl_pkg::BRL_IDLE;
            end
         end
         default: begin
            state_in = brl_pkg::BRL_IDLE;
         end
      endcase
   end

   // outputs of the state machine
   always_comb begin
      rec_pop = 1'b0;
      emit    = 1'b0;
      case (state_ff)
         brl_pkg::BRL_IDLE: rec_pop = rec_avail;
         brl_pkg::BRL_WALK: emit    = out_free;
         default: begin
            rec_pop = 1'b0;
            emit    = 1'b0;
         end
      endcase
   end

   // one Bresenham step: doubled error against -dz and dx
   always_comb begin
      e2     = {err_ff, 1'b0};
      dx_w   = signed'((EW + 1)'(dx_ff));
      dz_w   = signed'((EW + 1)'(dz_ff));
      x_step = (e2 > -dz_w);
      z_step = (e2 < dx_w);
      err_in = err_ff - (x_step ? signed'(EW'(dz_ff)) : '0)
                      + (z_step ? signed'(EW'(dx_ff)) : '0);
      px_in  = x_step ? (sx_neg_ff ? px_ff - 1'b1 : px_ff + 1'b1) : px_ff;
      pz_in  = z_step ? (sz_neg_ff ? pz_ff - 1'b1 : pz_ff + 1'b1) : pz_ff;
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (emit) begin
         out_valid_in = 1'b1;
      end else if (pt_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= brl_pkg::BRL_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == brl_pkg::BRL_LOAD) begin
         px_ff     <= rec_data[0*CB +: CB];
         pz_ff     <= rec_data[1*CB +: CB];
         ex_ff     <= rec_data[2*CB +: CB];
         ez_ff     <= rec_data[3*CB +: CB];
         dx_ff     <= rec_data[4*CB +: CB];
         dz_ff     <= rec_data[5*CB +: CB];
         sx_neg_ff <= rec_data[6*CB];
         sz_neg_ff <= rec_data[6*CB + 1];
         err_ff    <= signed'(rec_data[6*CB + 2 +: EW]);
      end else if (emit && !done) begin
         px_ff  <= px_in;
         pz_ff  <= pz_in;
         err_ff <= err_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         out_x_ff    <= px_ff;
         out_z_ff    <= pz_ff;
         out_last_ff <= done;
      end
   end

   assign pt_valid = out_valid_ff;
   assign pt_x     = out_x_ff;
   assign pt_z     = out_z_ff;
   assign pt_last  = out_last_ff;

   a_last_ends_walk: assert property (@(posedge clock) disable iff (reset)
      (emit && done) |=> (state_ff == brl_pkg::BRL_IDLE))
      else $error("walker kept stepping after the end point");

   a_pop_then_load: assert property (@(posedge clock) disable iff (reset)
      rec_pop |=> (state_ff == brl_pkg::BRL_LOAD))
      else $error("record popped without a load cycle");

   a_deltas_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == brl_pkg::BRL_WALK && state_in == brl_pkg::BRL_WALK)
         |=> ($stable(dx_ff) && $stable(dz_ff) && $stable(ex_ff) && $stable(ez_ff)))
      else $error("line setup changed during a walk");

   a_emit_fills_out: assert property (@(posedge clock) disable iff (reset)
      emit |=> out_valid_ff)
      else $error("emitted point did not reach the result register");

endmodule : brl_back

`default_nettype wire

// ----- sv/bresenham_line_rasterizer.sv -----
// ----------------------------------------------------------------------------
// bresenham_line_rasterizer - all-octant Bresenham line point generator
//
// Usage:
//   req_ channel: one beat is a line command (start and end on an x/z grid).
//   rsp_ channel: one beat per line point, start point first, end point last;
//                 rsp_tlast marks the end point. A line with start equal to
//                 end gives a single beat with rsp_tlast set.
//   A line has max(|dx|, |dz|) + 1 points, at most 2**COORD_BITS.
//   Path to the first point: command queue, queue read register, record
//   load, result register. Throughput: the walker makes one point per cycle
//   while rsp_ is not stalled, plus a queue read and record load per line.
//   A 2-entry command queue lets new commands in while a line is walked.
//   Stall: when rsp_tready is low the result register holds its beat and the
//   walker waits; commands keep landing in the queue until it is full, then
//   req_tready drops.
//   Reset (synchronous, active high) empties the queue, idles the walker and
//   drops rsp_tvalid. Lines are independent; nothing carries between them.
// ----------------------------------------------------------------------------
`default_nettype none

module bresenham_line_rasterizer #(
   parameter int unsigned COORD_BITS = 6
) (
   input  wire logic clock,
   input  wire logic reset,

   input  wire logic                                       req_tvalid,
   output      logic                                       req_tready,
   // req_tdata, low bit up: start_x, start_z, end_x, end_z, zero pad
   input  wire logic [((4 * COORD_BITS + 7) / 8) * 8 - 1:0] req_tdata,

   output      logic                                       rsp_tvalid,
   input  wire logic                                       rsp_tready,
   // rsp_tdata, low bit up: point_x, point_z, zero pad
   output      logic [((2 * COORD_BITS + 7) / 8) * 8 - 1:0] rsp_tdata,
   // rsp_tlast: last_point
   output      logic                                       rsp_tlast
);

   localparam int unsigned CB       = COORD_BITS;
   localparam int unsigned OUT_BITS = ((2 * CB + 7) / 8) * 8;
   localparam int unsigned REC_BITS = 7 * CB + brl_pkg::ERR_GUARD_BITS + 2;
   localparam int unsigned Q_DEPTH  = 2;

   logic [REC_BITS-1:0] setup_rec;
   logic [REC_BITS-1:0] rec_data;
   logic                q_full;
   logic                q_avail;
   logic                q_pop;
   logic                q_push;
   logic [CB-1:0]       pt_x;
   logic [CB-1:0]       pt_z;

   // Front: setup computed straight off the request beat.
   brl_front #(
      .COORD_BITS (CB),
      .REC_BITS   (REC_BITS)
   ) u_front (
      .start_x   (req_tdata[0*CB +: CB]),
      .start_z   (req_tdata[1*CB +: CB]),
      .end_x     (req_tdata[2*CB +: CB]),
      .end_z     (req_tdata[3*CB +: CB]),
      .setup_rec (setup_rec)
   );

   assign req_tready = !q_full;
   assign q_push     = req_tvalid && !q_full;

   brl_fifo #(
      .WIDTH (REC_BITS),
      .DEPTH (Q_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (setup_rec),
      .pop       (q_pop),
      .pop_data  (rec_data),
      .full      (q_full),
      .not_empty (q_avail)
   );

   // Back: walks one line at a time into the result register.
   brl_back #(
      .COORD_BITS (CB),
      .REC_BITS   (REC_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .rec_avail (q_avail),
      .rec_data  (rec_data),
      .rec_pop   (q_pop),
      .pt_valid  (rsp_tvalid),
      .pt_ready  (rsp_tready),
      .pt_x      (pt_x),
      .pt_z      (pt_z),
      .pt_last   (rsp_tlast)
   );

   assign rsp_tdata = OUT_BITS'({pt_z, pt_x});

endmodule : bresenham_line_rasterizer

`default_nettype wire

// ----- tb/tb_bresenham_line_rasterizer.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_bresenham_line_rasterizer - self-checking regression for the line rasterizer
// Sends line commands on req_ and predicts every point of each accepted line
// in the bench. Each rsp_ beat is checked in order against the oldest
// predicted point. The run covers three sender/receiver stall mixes.
// ----------------------------------------------------------------------------
module tb_bresenham_line_rasterizer;

   localparam int COORD_BITS   = 6;
   localparam int COORD_MAX    = (1 << COORD_BITS) - 1;
   localparam int MAX_POINTS   = 1 << COORD_BITS;
   localparam int REQ_W        = ((4 * COORD_BITS + 7) / 8) * 8;
   localparam int RSP_W        = ((2 * COORD_BITS + 7) / 8) * 8;
   localparam int RANDOM_LINES = 100;        // per stall phase
   // settle time after each drain; leave generous slack
   localparam int SETTLE_CYCLES = 16;
   // worst case is ~325 lines x 64 points with the receiver stalled 79% of the time;
   // the limit is set far above that
   localparam longint CYCLE_LIMIT = 1_000_000;

   typedef logic [COORD_BITS-1:0] coord_type;

   typedef struct {
      coord_type start_x;
      coord_type start_z;
      coord_type end_x;
      coord_type end_z;
   } line_cmd_type;

   typedef struct {
      coord_type x;
      coord_type z;
      logic      last;
   } line_point_type;

   typedef enum {
      LINE_ANY,      // both ends uniform over the grid
      LINE_SHORT,    // end within a few steps of the start
      LINE_STRAIGHT, // horizontal, vertical or diagonal
      LINE_DOT       // start equals end
   } line_kind_type;

   // ---------------------------------------------------------------------
   // DUT signals; every input has a known value from time zero
   // ---------------------------------------------------------------------
   logic             clock      = 1'b0;
   logic             reset      = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata  = '0;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;
   logic             rsp_tlast;

   // pending commands for the driver, predicted points for the monitor
   line_cmd_type   cmd_queue[$];
   line_point_type point_queue[$];

   int unsigned send_idle_pct = 15;
   int unsigned recv_idle_pct = 79;

   int     error_count = 0;
   int     lines_sent  = 0;
   int     points_seen = 0;
   int     dot_lines   = 0;
   int     full_lines  = 0;
   longint cycle_count = 0;

   bresenham_line_rasterizer #(
      .COORD_BITS(COORD_BITS)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tlast (rsp_tlast)
   );

   always #4 clock = ~clock;

   // ---------------------------------------------------------------------
   // Command packing: req_tdata low bit up is start_x, start_z, end_x, end_z
   // ---------------------------------------------------------------------
   function automatic logic [REQ_W-1:0] pack_cmd(input line_cmd_type cmd);
      return REQ_W'({cmd.end_z, cmd.end_x, cmd.start_z, cmd.start_x});
   endfunction

   function automatic line_cmd_type unpack_cmd(input logic [REQ_W-1:0] data);
      line_cmd_type cmd;
      cmd.start_x = data[COORD_BITS-1:0];
      cmd.start_z = data[2*COORD_BITS-1:COORD_BITS];
      cmd.end_x   = data[3*COORD_BITS-1:2*COORD_BITS];
      cmd.end_z   = data[4*COORD_BITS-1:3*COORD_BITS];
      return cmd;
   endfunction

   function automatic line_cmd_type make_cmd(input int sx, input int sz, input int ex,
                                             input int ez);
      line_cmd_type cmd;
      cmd.start_x = coord_type'(sx);
      cmd.start_z = coord_type'(sz);
      cmd.end_x   = coord_type'(ex);
      cmd.end_z   = coord_type'(ez);
      return cmd;
   endfunction

   function automatic int clamp_coord(input int v);
      if (v < 0)
         return 0;
      if (v > COORD_MAX)
         return COORD_MAX;
      return v;
   endfunction

   // ---------------------------------------------------------------------
   // Random line picker. Lines are mostly arbitrary or short. A share are
   // axis-aligned or diagonal before clamping, and a few are single points.
   // ---------------------------------------------------------------------
   function automatic line_cmd_type random_line();
      line_kind_type kind;
      int pick, sx, sz, ex, ez, len, dir;
      pick = $urandom_range(9);
      sx   = $urandom_range(COORD_MAX);
      sz   = $urandom_range(COORD_MAX);
      kind = (pick < 4) ? LINE_ANY : (pick < 7) ? LINE_SHORT :
             (pick < 9) ? LINE_STRAIGHT : LINE_DOT;
      case (kind)
         LINE_ANY: begin
            ex = $urandom_range(COORD_MAX);
            ez = $urandom_range(COORD_MAX);
         end
         LINE_SHORT: begin
            ex = clamp_coord(sx + int'($urandom_range(14)) - 7);
            ez = clamp_coord(sz + int'($urandom_range(14)) - 7);
         end
         LINE_STRAIGHT: begin
            len = $urandom_range(COORD_MAX);
            if ($urandom_range(1))
               len = -len;
            dir = $urandom_range(3);
            ex  = clamp_coord(sx + ((dir == 1) ? 0 : len));
            ez  = clamp_coord(sz + ((dir == 0) ? 0 : (dir == 3) ? -len : len));
         end
         default: begin
            ex = sx;
            ez = sz;
         end
      endcase
      return make_cmd(sx, sz, ex, ez);
   endfunction

   // ---------------------------------------------------------------------
   // Expected points of one line, in walk order. The error term starts at
   // dx - dz and is compared after doubling; both axes may step together.
   // ---------------------------------------------------------------------
   function automatic void rasterize_line(input line_cmd_type cmd);
      int px, pz, ex, ez, dx, dz, step_x, step_z, err, err2, count;
      bit at_end;
      line_point_type pt;
      px     = cmd.start_x;
      pz     = cmd.start_z;
      ex     = cmd.end_x;
      ez     = cmd.end_z;
      dx     = (ex >= px) ? ex - px : px - ex;
      dz     = (ez >= pz) ? ez - pz : pz - ez;
      step_x = (px < ex) ? 1 : -1;
      step_z = (pz < ez) ? 1 : -1;
      err    = dx - dz;
      count  = 0;
      do begin
         at_end  = (px == ex) && (pz == ez);
         pt.x    = coord_type'(px);
         pt.z    = coord_type'(pz);
         pt.last = at_end;
         point_queue.push_back(pt);
         count++;
         if (!at_end && count < MAX_POINTS) begin
            err2 = 2 * err;
            if (err2 > -dz) begin
               err -= dz;
               px  += step_x;
            end
            if (err2 < dx) begin
               err += dx;
               pz  += step_z;
            end
         end
      end while (!at_end && count < MAX_POINTS);
      lines_sent++;
      if (count == 1)
         dot_lines++;
      if (count == MAX_POINTS)
         full_lines++;
   endfunction

   // ---------------------------------------------------------------------
   // Driver: presents the next pending command when the channel is free,
   // idling at random by send_idle_pct. tvalid only changes once per edge.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (cmd_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_tdata  <= pack_cmd(cmd_queue.pop_front());
            req_tvalid <= 1'b1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Receiver stall: rsp_tready drops at random by recv_idle_pct.
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // ---------------------------------------------------------------------
   // Monitor: predicts each accepted command, then checks each rsp_ beat
   // against the oldest predicted point. Prediction runs first, which keeps
   // the queue order fixed within the edge.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : monitor
      line_point_type want;
      coord_type      got_x, got_z;
      logic [RSP_W-2*COORD_BITS-1:0] got_pad;
      if (!reset) begin
         if (req_tvalid && req_tready)
            rasterize_line(unpack_cmd(req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            points_seen++;
            got_x   = rsp_tdata[COORD_BITS-1:0];
            got_z   = rsp_tdata[2*COORD_BITS-1:COORD_BITS];
            got_pad = rsp_tdata[RSP_W-1:2*COORD_BITS];
            if (point_queue.size() == 0) begin
               error_count++;
               $display("%0t: unexpected point beat x=%0d z=%0d last=%b",
                        $time, got_x, got_z, rsp_tlast);
            end else begin
               want = point_queue.pop_front();
               if (got_x !== want.x) begin
                  error_count++;
                  $display("%0t: point_x expected %0d actual %0d", $time, want.x, got_x);
               end
               if (got_z !== want.z) begin
                  error_count++;
                  $display("%0t: point_z expected %0d actual %0d", $time, want.z, got_z);
               end
               if (rsp_tlast !== want.last) begin
                  error_count++;
                  $display("%0t: last_point at (%0d,%0d) expected %b actual %b",
                           $time, want.x, want.z, want.last, rsp_tlast);
               end
               if (got_pad !== '0) begin
                  error_count++;
                  $display("%0t: rsp_tdata pad expected 0 actual %h", $time, got_pad);
               end
            end
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles, %0d points still expected",
                  $time, cycle_count, point_queue.size());
         $display("bresenham_line_rasterizer regression: fail");
         $finish;
      end
   end

   // Holds off until nothing is queued, in flight or expected, then lets
   // the pipeline settle. Checked on the falling edge, after all updates.
   task automatic wait_drained();
      do
         @(negedge clock);
      while (cmd_queue.size() != 0 || req_tvalid || point_queue.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic queue_random_lines();
      for (int i = 0; i < RANDOM_LINES; i++)
         cmd_queue.push_back(random_line());
   endtask

   // ---------------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------------
   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: single points at both corners, full-length axis and
      // diagonal lines both ways, one line per octant, near-flat/near-steep
      // extremes, alternating bit patterns, one-step lines
      cmd_queue.push_back(make_cmd(0, 0, 0, 0));
      cmd_queue.push_back(make_cmd(63, 63, 63, 63));
      cmd_queue.push_back(make_cmd(0, 0, 63, 0));
      cmd_queue.push_back(make_cmd(63, 0, 0, 0));
      cmd_queue.push_back(make_cmd(0, 0, 0, 63));
      cmd_queue.push_back(make_cmd(0, 63, 0, 0));
      cmd_queue.push_back(make_cmd(0, 0, 63, 63));
      cmd_queue.push_back(make_cmd(63, 63, 0, 0));
      cmd_queue.push_back(make_cmd(63, 0, 0, 63));
      cmd_queue.push_back(make_cmd(0, 63, 63, 0));
      cmd_queue.push_back(make_cmd(32, 32, 40, 35));
      cmd_queue.push_back(make_cmd(32, 32, 35, 40));
      cmd_queue.push_back(make_cmd(32, 32, 24, 35));
      cmd_queue.push_back(make_cmd(32, 32, 29, 40));
      cmd_queue.push_back(make_cmd(32, 32, 24, 29));
      cmd_queue.push_back(make_cmd(32, 32, 29, 24));
      cmd_queue.push_back(make_cmd(32, 32, 40, 29));
      cmd_queue.push_back(make_cmd(32, 32, 35, 24));
      cmd_queue.push_back(make_cmd(0, 0, 63, 1));
      cmd_queue.push_back(make_cmd(0, 0, 1, 63));
      cmd_queue.push_back(make_cmd(21, 42, 42, 21));
      cmd_queue.push_back(make_cmd(42, 21, 21, 42));
      cmd_queue.push_back(make_cmd(5, 7, 6, 8));
      cmd_queue.push_back(make_cmd(10, 10, 11, 10));

      // phase 1: light sender idling, heavy receiver stall
      queue_random_lines();
      wait_drained();

      // phase 2: heavy sender idling, light receiver stall; the drain above
      // is also the full pause with every expected point delivered
      send_idle_pct = 79;
      recv_idle_pct = 15;
      queue_random_lines();
      wait_drained();

      // phase 3: both sides at full rate, back to back
      send_idle_pct = 0;
      recv_idle_pct = 0;
      queue_random_lines();
      wait_drained();

      $display("run: %0d lines, %0d points checked (%0d single-point, %0d of %0d points)",
               lines_sent, points_seen, dot_lines, full_lines, MAX_POINTS);
      $display("run: three stall mixes, sender-light, receiver-light and none; %0d errors",
               error_count);
      if (error_count == 0 && point_queue.size() == 0)
         $display("bresenham_line_rasterizer regression: pass");
      else
         $display("bresenham_line_rasterizer regression: fail");
      $finish;
   end

endmodule
